@@ hdl/rrts_pkg.sv @@
// Shared types and constants for the round robin target scheduler.
`default_nettype none

package rrts_pkg;

	// Size of the target table and the widths that follow from it.
	localparam int MAX_ENTRIES = 8;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// Fixed widths of the request and result fields.
	localparam int OP_W    = 3;
	localparam int ADDR_W  = 16;
	localparam int CTR_W   = 16;
	localparam int CODE_W  = 2;
	localparam int COUNT_W = 4;
	localparam int POS_W   = 3;

	localparam logic [ADDR_W-1:0] NO_ADDRESS = 16'h0000;
	localparam logic [CTR_W-1:0]  CTR_MAX    = 16'hFFFF;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_NEXT    = 3'd0,
		OP_CURRENT = 3'd1,
		OP_ADD     = 3'd2,
		OP_REMOVE  = 3'd3,
		OP_ENABLE  = 3'd4,
		OP_REPORT  = 3'd5,
		OP_CLEAR   = 3'd6,
		OP_STATUS  = 3'd7
	} op_t;

	// Result codes.
	typedef enum logic [CODE_W-1:0] {
		RES_OK        = 2'd0,
		RES_NOT_FOUND = 2'd1,
		RES_DUPLICATE = 2'd2,
		RES_FULL      = 2'd3
	} res_t;

	// One table entry as held in the entry memory.
	typedef struct packed {
		logic [ADDR_W-1:0] target;
		logic              enable;
		logic [CTR_W-1:0]  success;
		logic [CTR_W-1:0]  failure;
	} entry_t;

endpackage

`default_nettype wire

@@ hdl/round_robin_target_scheduler.sv @@
// Top level of the round robin target scheduler: sequencer around the entry memory.
`default_nettype none

// The scheduler holds up to MAX_ENTRIES targets (address, enable bit, saturating success
// and failure counters) in one entry memory with a single registered read port, and serves
// one request at a time. Status and clear pass through the fetch, fetch wait and output
// states; an empty next or current goes straight to the output state. Any request that
// needs a lookup or a round robin search reads one entry per cycle. A remove stops its
// search at the match and then moves each later entry down one place. A finished result
// sits in an output register, and the next request is accepted while it waits to be taken.
// Entries beyond the held count are never read, so no clearing pass follows reset.
module round_robin_target_scheduler (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [rrts_pkg::OP_W-1:0]     operation,
	input  wire logic [rrts_pkg::ADDR_W-1:0]   address,
	input  wire logic                          flag,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [rrts_pkg::CODE_W-1:0]        result_code,
	output logic [rrts_pkg::ADDR_W-1:0]        target_address,
	output logic [rrts_pkg::COUNT_W-1:0]       entry_count,
	output logic [rrts_pkg::POS_W-1:0]         current_position,
	output logic [rrts_pkg::CTR_W-1:0]         success_total,
	output logic [rrts_pkg::CTR_W-1:0]         failure_total
);

	localparam int IDX_W = rrts_pkg::IDX_W;
	localparam int CNT_W = rrts_pkg::CNT_W;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_SHIFT = 6'b000100,
		S_FETCH = 6'b001000,
		S_FWAIT = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	// Entry memory and its ports.
	rrts_pkg::entry_t mem [rrts_pkg::MAX_ENTRIES];
	rrts_pkg::entry_t rdata_q;
	rrts_pkg::entry_t wr_data;
	logic             rd_en, wr_en;
	logic [IDX_W-1:0] rd_idx, wr_idx;

	// Control state.
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] ptr_q, ptr_d;
	logic             out_valid_q, out_valid_d;
	logic             chk_v_s1, chk_v_d;

	// Request and working registers.
	rrts_pkg::op_t                op_q, op_d;
	logic [rrts_pkg::ADDR_W-1:0]  addr_q, addr_d;
	logic                         flag_q, flag_d;
	rrts_pkg::res_t               code_q, code_d;
	logic [rrts_pkg::ADDR_W-1:0]  tgt_q, tgt_d;
	logic [rrts_pkg::CTR_W-1:0]   succ_q, succ_d, fail_q, fail_d;
	logic [IDX_W-1:0]             iss_idx_q, iss_idx_d;
	logic [CNT_W-1:0]             iss_left_q, iss_left_d;
	logic [IDX_W-1:0]             chk_idx_s1, chk_idx_d;

	// Result register.
	logic                         out_load;
	rrts_pkg::res_t               res_code_q;
	logic [rrts_pkg::ADDR_W-1:0]  res_tgt_q;
	logic [CNT_W-1:0]             res_count_q;
	logic [IDX_W-1:0]             res_pos_q;
	logic [rrts_pkg::CTR_W-1:0]   res_succ_q, res_fail_q;

	// Helper terms.
	logic                         is_search, hit, ptr_in_range;
	logic [IDX_W-1:0]             idx_inc, ptr_inc;
	logic [CNT_W-1:0]             count_dec;
	logic [rrts_pkg::CTR_W-1:0]   succ_new, fail_new;

	assign in_ready = (state_q == S_IDLE);

	assign is_search    = (op_q == rrts_pkg::OP_NEXT) || (op_q == rrts_pkg::OP_CURRENT);
	assign hit          = chk_v_s1 && (is_search ? rdata_q.enable : (rdata_q.target == addr_q));
	assign ptr_in_range = (CNT_W'(ptr_q) < count_q);
	assign count_dec    = count_q - CNT_W'(1);

	// Round robin steps wrap at the held count.
	assign idx_inc = ((CNT_W'(iss_idx_q) + CNT_W'(1)) >= count_q) ? '0 : iss_idx_q + IDX_W'(1);
	assign ptr_inc = ((CNT_W'(ptr_q) + CNT_W'(1)) >= count_q) ? '0 : ptr_q + IDX_W'(1);

	// Saturating counter update for a report.
	always_comb begin
		succ_new = rdata_q.success;
		fail_new = rdata_q.failure;
		if (flag_q) begin
			if (rdata_q.success != rrts_pkg::CTR_MAX) succ_new = rdata_q.success + 16'd1;
		end else begin
			if (rdata_q.failure != rrts_pkg::CTR_MAX) fail_new = rdata_q.failure + 16'd1;
		end
	end

	// Sequencer: scans, shifts and write-backs on the entry memory.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		ptr_d       = ptr_q;
		out_valid_d = out_valid_q && !out_ready;
		chk_v_d     = 1'b0;
		op_d        = op_q;
		addr_d      = addr_q;
		flag_d      = flag_q;
		code_d      = code_q;
		tgt_d       = tgt_q;
		succ_d      = succ_q;
		fail_d      = fail_q;
		iss_idx_d   = iss_idx_q;
		iss_left_d  = iss_left_q;
		chk_idx_d   = chk_idx_s1;
		rd_en       = 1'b0;
		rd_idx      = iss_idx_q;
		wr_en       = 1'b0;
		wr_idx      = chk_idx_s1;
		wr_data     = rdata_q;
		out_load    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d       = rrts_pkg::op_t'(operation);
					addr_d     = address;
					flag_d     = flag;
					code_d     = rrts_pkg::RES_OK;
					tgt_d      = rrts_pkg::NO_ADDRESS;
					succ_d     = '0;
					fail_d     = '0;
					iss_idx_d  = '0;
					iss_left_d = count_q;
					unique case (rrts_pkg::op_t'(operation))
						rrts_pkg::OP_NEXT: begin
							if (count_q == '0) begin
								code_d  = rrts_pkg::RES_NOT_FOUND;
								state_d = S_OUT;
							end else begin
								iss_idx_d = ptr_inc;
								state_d   = S_SCAN;
							end
						end
						rrts_pkg::OP_CURRENT: begin
							if (count_q == '0) begin
								code_d  = rrts_pkg::RES_NOT_FOUND;
								state_d = S_OUT;
							end else begin
								if (!ptr_in_range) begin
									ptr_d     = '0;
									iss_idx_d = '0;
								end else begin
									iss_idx_d = ptr_q;
								end
								state_d = S_SCAN;
							end
						end
						rrts_pkg::OP_ADD: begin
							if (count_q >= CNT_W'(rrts_pkg::MAX_ENTRIES)) begin
								code_d  = rrts_pkg::RES_FULL;
								state_d = S_FETCH;
							end else begin
								state_d = S_SCAN;
							end
						end
						rrts_pkg::OP_REMOVE, rrts_pkg::OP_ENABLE, rrts_pkg::OP_REPORT: begin
							state_d = S_SCAN;
						end
						rrts_pkg::OP_CLEAR: begin
							count_d = '0;
							ptr_d   = '0;
							state_d = S_FETCH;
						end
						rrts_pkg::OP_STATUS: begin
							state_d = S_FETCH;
						end
					endcase
				end
			end

			S_SCAN: begin
				if (hit) begin
					// Matching entry found at the index whose data has just returned.
					unique case (op_q)
						rrts_pkg::OP_NEXT, rrts_pkg::OP_CURRENT: begin
							ptr_d   = chk_idx_s1;
							tgt_d   = rdata_q.target;
							state_d = S_OUT;
						end
						rrts_pkg::OP_ADD: begin
							code_d  = rrts_pkg::RES_DUPLICATE;
							state_d = S_FETCH;
						end
						rrts_pkg::OP_REMOVE: begin
							iss_idx_d  = chk_idx_s1 + IDX_W'(1);
							iss_left_d = count_dec - CNT_W'(chk_idx_s1);
							state_d    = S_SHIFT;
						end
						rrts_pkg::OP_ENABLE: begin
							wr_en          = 1'b1;
							wr_data.enable = flag_q;
							state_d        = S_FETCH;
						end
						rrts_pkg::OP_REPORT: begin
							wr_en           = 1'b1;
							wr_data.success = succ_new;
							wr_data.failure = fail_new;
							succ_d          = succ_new;
							fail_d          = fail_new;
							state_d         = S_FETCH;
						end
						rrts_pkg::OP_CLEAR, rrts_pkg::OP_STATUS: begin
							state_d = S_FETCH;
						end
					endcase
				end else if (iss_left_q == '0) begin
					// Every candidate has been checked without a match.
					unique case (op_q)
						rrts_pkg::OP_NEXT, rrts_pkg::OP_CURRENT: begin
							code_d  = rrts_pkg::RES_NOT_FOUND;
							state_d = S_OUT;
						end
						rrts_pkg::OP_ADD: begin
							wr_en           = 1'b1;
							wr_idx          = count_q[IDX_W-1:0];
							wr_data.target  = addr_q;
							wr_data.enable  = 1'b1;
							wr_data.success = '0;
							wr_data.failure = '0;
							count_d         = count_q + CNT_W'(1);
							state_d         = S_FETCH;
						end
						default: begin
							code_d  = rrts_pkg::RES_NOT_FOUND;
							state_d = S_FETCH;
						end
					endcase
				end else begin
					rd_en      = 1'b1;
					iss_idx_d  = idx_inc;
					iss_left_d = iss_left_q - CNT_W'(1);
					chk_idx_d  = iss_idx_q;
					chk_v_d    = 1'b1;
				end
			end

			S_SHIFT: begin
				// Each later entry is read and written one place lower.
				if (chk_v_s1) begin
					wr_en  = 1'b1;
					wr_idx = chk_idx_s1 - IDX_W'(1);
				end
				if (iss_left_q != '0) begin
					rd_en      = 1'b1;
					iss_idx_d  = iss_idx_q + IDX_W'(1);
					iss_left_d = iss_left_q - CNT_W'(1);
					chk_idx_d  = iss_idx_q;
					chk_v_d    = 1'b1;
				end else begin
					count_d = count_dec;
					if ((count_dec != '0) && (CNT_W'(ptr_q) >= count_dec)) ptr_d = '0;
					state_d = S_FETCH;
				end
			end

			S_FETCH: begin
				rd_en   = ptr_in_range;
				rd_idx  = ptr_q;
				state_d = S_FWAIT;
			end

			S_FWAIT: begin
				tgt_d   = ptr_in_range ? rdata_q.target : rrts_pkg::NO_ADDRESS;
				state_d = S_OUT;
			end

			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Entry memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_idx];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
			chk_v_s1    <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			ptr_q       <= ptr_d;
			out_valid_q <= out_valid_d;
			chk_v_s1    <= chk_v_d;
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		op_q       <= op_d;
		addr_q     <= addr_d;
		flag_q     <= flag_d;
		code_q     <= code_d;
		tgt_q      <= tgt_d;
		succ_q     <= succ_d;
		fail_q     <= fail_d;
		iss_idx_q  <= iss_idx_d;
		iss_left_q <= iss_left_d;
		chk_idx_s1 <= chk_idx_d;
		if (out_load) begin
			res_code_q  <= code_q;
			res_tgt_q   <= tgt_q;
			res_count_q <= count_q;
			res_pos_q   <= ptr_q;
			res_succ_q  <= succ_q;
			res_fail_q  <= fail_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign result_code      = res_code_q;
	assign target_address   = res_tgt_q;
	assign entry_count      = rrts_pkg::COUNT_W'(res_count_q);
	assign current_position = rrts_pkg::POS_W'(res_pos_q);
	assign success_total    = res_succ_q;
	assign failure_total    = res_fail_q;

`ifndef SYNTH
	// The pointer stays inside the table, and rests at zero when the table is empty.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) ? (ptr_q == '0) : (CNT_W'(ptr_q) < count_q))
		else $error("round robin pointer outside the table");

	// The held count never exceeds the table size.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(rrts_pkg::MAX_ENTRIES))
		else $error("held count above table size");

	// Data under check always comes from an occupied entry.
	a_chk_range: assert property (@(posedge clk) disable iff (!arst_n)
		chk_v_s1 |-> (CNT_W'(chk_idx_s1) < count_q))
		else $error("checked entry beyond held count");

	// A read and a write never meet at the same entry in one cycle.
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_idx != wr_idx))
		else $error("read and write collide on one entry");

	// A result is raised only from the output state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");
`endif

endmodule

`default_nettype wire
